FILE: src/cmb_pkg.sv
// ----------------------------------------------------------------------------
// Combination successor package
// Shared constants, codes and types for the combination successor block.
// ----------------------------------------------------------------------------
package cmb_pkg;

  localparam int MAX_STRENGTH = 8;
  localparam int MAX_ELEMENTS = 256;

  localparam int ENTRY_W     = 8;
  localparam int SLOT_W      = 3;
  localparam int COUNT_W     = 9;
  localparam int STRENGTH_W  = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;

  localparam int KEFF_W = $clog2(MAX_STRENGTH + 1);
  localparam int IDX_W  = (MAX_STRENGTH > 1) ? $clog2(MAX_STRENGTH) : 1;
  localparam int CMP_W  = 12;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_ELEMENT_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STRENGTH      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LEXICAL_ORDER = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_REFILL,
    ST_EMIT,
    ST_ZERO
  } state_t;

  typedef struct packed {
    logic               load;
    logic               decide_lex;
    logic               decide_colex;
    logic               refill;
    logic               rotate;
    logic [KEFF_W-1:0]  k;
    logic [COUNT_W-1:0] n;
    logic [SLOT_W-1:0]  slot;
    logic [ENTRY_W-1:0] value;
  } cell_ctrl_t;

endpackage

FILE: src/cmb_cell.sv
// ----------------------------------------------------------------------------
// Combination successor cell
// Holds one entry of the combination and takes part in the pivot search chains.
// ----------------------------------------------------------------------------
module cmb_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  cmb_pkg::cell_ctrl_t           ctrl,
  input  logic [cmb_pkg::IDX_W-1:0]     index,
  input  logic [cmb_pkg::ENTRY_W-1:0]   left_entry,
  input  logic [cmb_pkg::ENTRY_W-1:0]   right_entry,
  input  logic                          found_lo_in,
  input  logic                          found_hi_in,
  output logic [cmb_pkg::ENTRY_W-1:0]   entry,
  output logic                          found_lo_out,
  output logic                          found_hi_out,
  output logic                          not_last
);

  logic                      refill_mark;
  logic [cmb_pkg::CMP_W-1:0] s_w;
  logic [cmb_pkg::CMP_W-1:0] k_w;
  logic [cmb_pkg::CMP_W-1:0] n_w;
  logic [cmb_pkg::CMP_W-1:0] i_w;
  logic                      in_use;
  logic                      grow;
  logic                      cand;
  logic                      hit;

  assign s_w = cmb_pkg::CMP_W'(entry);
  assign k_w = cmb_pkg::CMP_W'(ctrl.k);
  assign n_w = cmb_pkg::CMP_W'(ctrl.n);
  assign i_w = cmb_pkg::CMP_W'(index);

  assign in_use   = i_w < k_w;
  assign grow     = in_use && (s_w + k_w < n_w + i_w);
  assign cand     = in_use && ((i_w + cmb_pkg::CMP_W'(1) == k_w) ||
                    (s_w + cmb_pkg::CMP_W'(1) != cmb_pkg::CMP_W'(right_entry)));
  assign not_last = in_use && (s_w != n_w - k_w + i_w);
  assign hit      = cmb_pkg::CMP_W'(ctrl.slot) == i_w;

  assign found_hi_out = found_hi_in | grow;
  assign found_lo_out = found_lo_in | cand;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry       <= cmb_pkg::ENTRY_W'(index);
      refill_mark <= 1'b0;
    end else begin
      if (ctrl.load) begin
        if (hit) begin
          entry <= ctrl.value;
        end
      end else if (ctrl.decide_lex) begin
        if (grow && !found_hi_in) begin
          entry <= entry + cmb_pkg::ENTRY_W'(1);
        end
      end else if (ctrl.decide_colex) begin
        if (cand && !found_lo_in) begin
          entry <= entry + cmb_pkg::ENTRY_W'(1);
        end else if (!found_lo_out) begin
          entry <= cmb_pkg::ENTRY_W'(index);
        end
      end else if (ctrl.refill) begin
        if (refill_mark) begin
          entry <= left_entry + cmb_pkg::ENTRY_W'(1);
        end
      end else if (ctrl.rotate) begin
        entry <= right_entry;
      end
      if (ctrl.decide_lex) begin
        refill_mark <= in_use && !found_hi_out;
      end
    end
  end

endmodule

FILE: src/combination_successor.sv
// Load: no result. Advance with strength zero: one result.
// Advance otherwise: a decide state, a refill pass for a lexical step, then a full
// rotation that delivers the entries in use, one per cycle, from cell 0.
// A new item is taken after the last rotation; output stalls lengthen the rotation.
// Reset (synchronous, active high) loads entry i with i and the registers with 8, 2, 1.
// ----------------------------------------------------------------------------
// Combination successor
// Steps a stored sorted subset to its lexical or colex successor in a row of cells.
// ----------------------------------------------------------------------------
module combination_successor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              opcode,
  input  logic [cmb_pkg::SLOT_W-1:0]        slot,
  input  logic [cmb_pkg::ENTRY_W-1:0]       value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cmb_pkg::SLOT_W-1:0]        position,
  output logic [cmb_pkg::ENTRY_W-1:0]       element,
  output logic                              advanced,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cmb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [cmb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam logic [cmb_pkg::KEFF_W-1:0] CNT_LAST =
    cmb_pkg::KEFF_W'(cmb_pkg::MAX_STRENGTH - 1);

  cmb_pkg::state_t              state;
  cmb_pkg::state_t              state_next;
  logic [cmb_pkg::KEFF_W-1:0]   cnt;
  logic [cmb_pkg::KEFF_W-1:0]   cnt_next;
  logic [cmb_pkg::COUNT_W-1:0]  element_count;
  logic [cmb_pkg::STRENGTH_W-1:0] strength;
  logic                         lexical_order;
  logic                         stepped;

  logic [cmb_pkg::KEFF_W-1:0]   k_eff;
  logic [cmb_pkg::COUNT_W-1:0]  n_eff;
  logic                         step_ok;
  logic                         lex_step;
  logic                         colex_step;
  logic                         accept;
  logic                         out_free;
  logic                         emit_due;
  logic                         emit_go;
  logic                         emit_load;
  cmb_pkg::cell_ctrl_t          ctrl;

  logic [cmb_pkg::ENTRY_W-1:0]  entries [cmb_pkg::MAX_STRENGTH];
  logic                         found_lo [cmb_pkg::MAX_STRENGTH+1];
  logic                         found_hi [cmb_pkg::MAX_STRENGTH+1];
  logic [cmb_pkg::MAX_STRENGTH-1:0] not_last_v;

  assign k_eff = (32'(strength) > cmb_pkg::MAX_STRENGTH) ?
                 cmb_pkg::KEFF_W'(cmb_pkg::MAX_STRENGTH) : cmb_pkg::KEFF_W'(strength);
  assign n_eff = (32'(element_count) > cmb_pkg::MAX_ELEMENTS) ?
                 cmb_pkg::COUNT_W'(cmb_pkg::MAX_ELEMENTS) : element_count;
  assign step_ok    = (n_eff != '0) && (32'(k_eff) < 32'(n_eff));
  assign lex_step   = step_ok && lexical_order && found_hi[0];
  assign colex_step = step_ok && !lexical_order && (|not_last_v);

  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign emit_due  = (state == cmb_pkg::ST_EMIT) && (cnt < k_eff);
  assign emit_go   = (state == cmb_pkg::ST_EMIT) && (!emit_due || out_free);
  assign emit_load = (emit_due && out_free) || ((state == cmb_pkg::ST_ZERO) && out_free);
  assign cfg_ready = 1'b1;

  assign found_lo[0] = 1'b0;
  assign found_hi[cmb_pkg::MAX_STRENGTH] = 1'b0;

  for (genvar g = 0; g < cmb_pkg::MAX_STRENGTH; g++) begin : g_cell
    cmb_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .index        (cmb_pkg::IDX_W'(g)),
      .left_entry   (entries[(g + cmb_pkg::MAX_STRENGTH - 1) % cmb_pkg::MAX_STRENGTH]),
      .right_entry  (entries[(g + 1) % cmb_pkg::MAX_STRENGTH]),
      .found_lo_in  (found_lo[g]),
      .found_hi_in  (found_hi[g+1]),
      .entry        (entries[g]),
      .found_lo_out (found_lo[g+1]),
      .found_hi_out (found_hi[g]),
      .not_last     (not_last_v[g])
    );
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      cmb_pkg::ST_IDLE: begin
        if (accept && (opcode == cmb_pkg::OP_ADVANCE)) begin
          state_next = (k_eff == '0) ? cmb_pkg::ST_ZERO : cmb_pkg::ST_DECIDE;
        end
        cnt_next = '0;
      end
      cmb_pkg::ST_DECIDE: begin
        state_next = lex_step ? cmb_pkg::ST_REFILL : cmb_pkg::ST_EMIT;
        cnt_next   = '0;
      end
      cmb_pkg::ST_REFILL: begin
        if (cnt == CNT_LAST) begin
          state_next = cmb_pkg::ST_EMIT;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + cmb_pkg::KEFF_W'(1);
        end
      end
      cmb_pkg::ST_EMIT: begin
        if (emit_go) begin
          if (cnt == CNT_LAST) begin
            state_next = cmb_pkg::ST_IDLE;
            cnt_next   = '0;
          end else begin
            cnt_next = cnt + cmb_pkg::KEFF_W'(1);
          end
        end
      end
      cmb_pkg::ST_ZERO: begin
        if (out_free) begin
          state_next = cmb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cmb_pkg::ST_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  always_comb begin
    in_ready          = (state == cmb_pkg::ST_IDLE);
    ctrl.load         = accept && (opcode == cmb_pkg::OP_LOAD);
    ctrl.decide_lex   = (state == cmb_pkg::ST_DECIDE) && lex_step;
    ctrl.decide_colex = (state == cmb_pkg::ST_DECIDE) && colex_step;
    ctrl.refill       = (state == cmb_pkg::ST_REFILL);
    ctrl.rotate       = emit_go;
    ctrl.k            = k_eff;
    ctrl.n            = n_eff;
    ctrl.slot         = slot;
    ctrl.value        = value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= cmb_pkg::ST_IDLE;
      cnt           <= '0;
      stepped       <= 1'b0;
      out_valid     <= 1'b0;
      element_count <= cmb_pkg::COUNT_W'(8);
      strength      <= cmb_pkg::STRENGTH_W'(2);
      lexical_order <= 1'b1;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (state == cmb_pkg::ST_DECIDE) begin
        stepped <= lex_step || colex_step;
      end
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          cmb_pkg::REG_ELEMENT_COUNT: element_count <= cfg_data;
          cmb_pkg::REG_STRENGTH:      strength <= cmb_pkg::STRENGTH_W'(cfg_data);
          cmb_pkg::REG_LEXICAL_ORDER: lexical_order <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      if (state == cmb_pkg::ST_ZERO) begin
        position <= '0;
        element  <= '0;
        advanced <= 1'b0;
        last     <= 1'b1;
      end else begin
        position <= cmb_pkg::SLOT_W'(cnt);
        element  <= entries[0];
        advanced <= stepped;
        last     <= (cnt + cmb_pkg::KEFF_W'(1) == k_eff);
      end
    end
  end

`ifndef SYNTHESIS
  a_zero_path: assert property (@(posedge clk) disable iff (rst)
    (accept && (opcode == cmb_pkg::OP_ADVANCE) && (k_eff == '0)) |=>
    (state == cmb_pkg::ST_ZERO))
    else $error("strength zero advance did not take the single result path");

  a_decide_once: assert property (@(posedge clk) disable iff (rst)
    (state == cmb_pkg::ST_DECIDE) |=>
    ((state == cmb_pkg::ST_REFILL) || (state == cmb_pkg::ST_EMIT)))
    else $error("decide phase did not move on to refill or emit");

  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    (cnt != '0) |-> ((state == cmb_pkg::ST_REFILL) || (state == cmb_pkg::ST_EMIT)))
    else $error("cycle counter running outside refill or emit");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    emit_load |=> out_valid)
    else $error("emitted result did not reach the output register");
`endif

endmodule
